// ===== rtl/core/tfu_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package tfu_pkg;

	// fixed field widths
	localparam int TIME_W = 32;
	localparam int WIN_W  = 9;
	localparam int LIM_W  = 11;
	localparam int OHM_W  = 16;
	localparam int RES_W  = 47;
	localparam int CMD_W  = 2;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 16;
	localparam int FRAME_LO_W = 64;
	localparam int FRAME_HI_W = 56;

	// input commands
	localparam logic [CMD_W-1:0] CMD_FRAME  = 2'd0;
	localparam logic [CMD_W-1:0] CMD_CLEAR  = 2'd1;
	localparam logic [CMD_W-1:0] CMD_PAUSE  = 2'd2;
	localparam logic [CMD_W-1:0] CMD_RESUME = 2'd3;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_MATCH_WINDOW = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_TICK_LIMIT   = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_REF_OHMS     = 2'd2;

	// register reset values
	localparam logic [WIN_W-1:0] WIN_RESET = 9'd50;
	localparam logic [LIM_W-1:0] LIM_RESET = 11'd1000;
	localparam logic [OHM_W-1:0] OHM_RESET = 16'd4990;

	// time base after clear or pause: -5000
	localparam logic [TIME_W-1:0] BASE_AFTER_CLEAR = 32'hFFFF_EC78;

	localparam logic [RES_W-1:0] RES_MAX = {RES_W{1'b1}};

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_SEL,
		ST_DIFF,
		ST_UNW0,
		ST_UNW1,
		ST_UNW2,
		ST_MUL,
		ST_DIV,
		ST_OUT
	} tfu_state_t;

endpackage

`default_nettype wire

// ===== rtl/core/telemetry_frame_unwrap_resistance_unit.sv =====
`timescale 1ns / 1ps
`default_nettype none
// telemetry frame unwrapper and resistance converter
// input channel (in_valid/in_ready): one word per command; cmd selects frame, clear history,
// pause or resume. a frame word holds a tick count and SAMPLES_PER_FRAME packed adc samples.
// output channel (out_valid/out_ready): one word per kept sample, oldest first, carrying the
// raw tick, the unwrapped 32-bit time, the sample, the resistance in q8 and a saturation flag;
// last_of_frame marks the final word of a frame. frames with every tick skipped, paused
// frames and the three commands produce no output word.
// configuration: cfg_we writes cfg_data into register cfg_index at the clock edge
// (0 match window, 1 valid tick limit, 2 reference ohms); write only while idle.
// timing: each kept sample runs through a small sequencer: select, difference, up to three
// distance checks on one shared compare unit, one multiply, then a restoring divider
// that retires one quotient bit per cycle; a skipped sample only passes through select.
// in_ready is high only while idle, so a new word is taken only once the frame is through.
// stall: the result word holds on the output until out_ready; the sequencer waits meanwhile.
// reset: asynchronous, clears time base, newest time, history and pause flag and restores
// the register defaults.

module telemetry_frame_unwrap_resistance_unit
	import tfu_pkg::*;
#(
	parameter int SAMPLES_PER_FRAME = 5,
	parameter int SAMPLE_BITS       = 22,
	parameter int TICK_BITS         = 10
) (
	input  wire                          clk,
	input  wire                          arst_n,

	input  wire                          cfg_we,
	input  wire  [CFG_IDX_W-1:0]         cfg_index,
	input  wire  [CFG_DATA_W-1:0]        cfg_data,

	input  wire                          in_valid,
	output logic                         in_ready,
	input  wire  [CMD_W-1:0]             cmd,
	input  wire  [FRAME_LO_W-1:0]        frame_low,
	input  wire  [FRAME_HI_W-1:0]        frame_high,

	output logic                         out_valid,
	input  wire                          out_ready,
	output logic [TICK_BITS-1:0]         raw_tick,
	output logic signed [TIME_W-1:0]     sample_time,
	output logic signed [SAMPLE_BITS-1:0] adc_value,
	output logic [RES_W-1:0]             resistance_q8,
	output logic                         saturated,
	output logic                         last_of_frame
);

	localparam int SPF     = SAMPLES_PER_FRAME;
	localparam int SB      = SAMPLE_BITS;
	localparam int IDX_W   = (SPF > 1) ? $clog2(SPF) : 1;
	localparam int IN_W    = FRAME_LO_W + FRAME_HI_W;
	localparam int FRAME_W = TICK_BITS + SPF * SB;
	localparam int FULL_W  = (FRAME_W > IN_W) ? FRAME_W : IN_W;
	localparam int PROD_W  = OHM_W + SB;
	localparam int DVD_W   = PROD_W + 8;
	localparam int CNT_W   = $clog2(DVD_W);
	localparam int QW      = (DVD_W > RES_W) ? DVD_W : RES_W;
	localparam int CMP_W   = (TICK_BITS > LIM_W) ? TICK_BITS : LIM_W;
	localparam logic [TIME_W-1:0] WRAP = TIME_W'(1) << TICK_BITS;
	localparam logic [SB:0]       HALF = (SB + 1)'(1) << (SB - 1);

	tfu_state_t state_q, state_d;

	// configuration
	logic [WIN_W-1:0]  win_q;
	logic [LIM_W-1:0]  lim_q;
	logic [OHM_W-1:0]  ohm_q;

	// history
	logic [TIME_W-1:0] base_q;
	logic [TIME_W-1:0] newest_q;
	logic              have_q;
	logic              paused_q;

	// frame work registers
	logic [FRAME_LO_W-1:0] flo_q;
	logic [FRAME_HI_W-1:0] fhi_q;
	logic [SPF-1:0]        keep_q;
	logic [IDX_W-1:0]      idx_q;
	logic [TICK_BITS-1:0]  tick_q;
	logic [TIME_W-1:0]     utime_q;
	logic [TIME_W-1:0]     nref_q;
	logic [TIME_W-1:0]     diff_q;

	// divider
	logic [DVD_W-1:0] dvd_q;
	logic [SB-1:0]    rem_q;
	logic [SB-1:0]    den_q;
	logic [CNT_W-1:0] cnt_q;
	logic             sat_q;

	logic in_fire;
	logic out_fire;
	assign in_fire  = in_valid && in_ready;
	assign out_fire = out_valid && out_ready;

	// tick of each sample from the incoming word, checked against the limit
	logic [TICK_BITS-1:0] in_start;
	logic [SPF-1:0]       in_keep;
	assign in_start = frame_low[TICK_BITS-1:0];
	always_comb begin
		for (int i = 0; i < SPF; i++) begin
			in_keep[i] = CMP_W'(TICK_BITS'(in_start - TICK_BITS'(i))) < CMP_W'(lim_q);
		end
	end

	// sample slices of the stored frame; bits past the word read as zero
	logic [FULL_W-1:0] full;
	logic [SB-1:0]     samp_arr [SPF];
	logic [SB-1:0]     samp;
	assign full = FULL_W'({fhi_q, flo_q});
	for (genvar gi = 0; gi < SPF; gi++) begin : g_slice
		assign samp_arr[gi] = full[TICK_BITS + gi * SB +: SB];
	end
	assign samp = samp_arr[idx_q];

	// tick of the current sample
	logic [TICK_BITS-1:0] tick_cur;
	assign tick_cur = TICK_BITS'(flo_q[TICK_BITS-1:0] - TICK_BITS'(idx_q));

	// shared distance unit: |diff + offset| <= window
	logic [TIME_W-1:0] off_sel;
	logic [TIME_W-1:0] dsum;
	logic [TIME_W-1:0] dabs;
	logic              in_win;
	always_comb begin
		case (state_q)
			ST_UNW1: off_sel = TIME_W'(0) - WRAP;
			ST_UNW2: off_sel = WRAP;
			default: off_sel = '0;
		endcase
	end
	assign dsum   = diff_q + off_sel;
	assign dabs   = dsum[TIME_W-1] ? (TIME_W'(0) - dsum) : dsum;
	assign in_win = dabs <= TIME_W'(win_q);

	// divider equation operands: H - v and H + v
	logic [SB:0]   samp_ext;
	logic [SB:0]   num_full;
	logic [SB:0]   den_full;
	logic [PROD_W-1:0] prod;
	assign samp_ext = {samp[SB-1], samp};
	assign num_full = HALF - samp_ext;
	assign den_full = HALF + samp_ext;
	assign prod     = PROD_W'(ohm_q) * PROD_W'(num_full[SB-1:0]);

	// one restoring step
	logic [SB:0] rem_sh;
	logic [SB:0] rem_sub;
	logic        ge;
	assign rem_sh  = {rem_q, dvd_q[DVD_W-1]};
	assign rem_sub = rem_sh - {1'b0, den_q};
	assign ge      = rem_sh >= {1'b0, den_q};

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_fire && cmd == CMD_FRAME && !paused_q && |in_keep) begin
					state_d = ST_SEL;
				end
			end
			ST_SEL: begin
				if (keep_q[idx_q]) begin
					state_d = ST_DIFF;
				end else if (idx_q == '0) begin
					state_d = ST_IDLE;
				end
			end
			ST_DIFF: state_d = ST_UNW0;
			ST_UNW0: state_d = in_win ? ST_MUL : ST_UNW1;
			ST_UNW1: state_d = in_win ? ST_MUL : ST_UNW2;
			ST_UNW2: state_d = ST_MUL;
			ST_MUL:  state_d = ST_DIV;
			ST_DIV: begin
				if (cnt_q == '0) begin
					state_d = ST_OUT;
				end
			end
			ST_OUT: begin
				if (out_ready) begin
					state_d = (idx_q == '0) ? ST_IDLE : ST_SEL;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// handshake outputs
	always_comb begin
		in_ready  = 1'b0;
		out_valid = 1'b0;
		unique case (state_q)
			ST_IDLE: in_ready  = 1'b1;
			ST_OUT:  out_valid = 1'b1;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_q <= WIN_RESET;
			lim_q <= LIM_RESET;
			ohm_q <= OHM_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_MATCH_WINDOW: win_q <= cfg_data[WIN_W-1:0];
				REG_TICK_LIMIT:   lim_q <= cfg_data[LIM_W-1:0];
				REG_REF_OHMS:     ohm_q <= cfg_data[OHM_W-1:0];
				default: ;
			endcase
		end
	end

	// history and command handling
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_q   <= '0;
			newest_q <= '0;
			have_q   <= 1'b0;
			paused_q <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (in_fire) begin
						unique case (cmd)
							CMD_CLEAR: begin
								have_q   <= 1'b0;
								newest_q <= '0;
								base_q   <= BASE_AFTER_CLEAR;
							end
							CMD_PAUSE: begin
								paused_q <= 1'b1;
								base_q   <= BASE_AFTER_CLEAR;
							end
							CMD_RESUME: paused_q <= 1'b0;
							default: ;
						endcase
					end
				end
				// wrap down or up by one tick period, else rebase just past the newest
				ST_UNW1: begin
					if (in_win) begin
						base_q <= base_q - WRAP;
					end
				end
				ST_UNW2: begin
					if (in_win) begin
						base_q <= base_q + WRAP;
					end else begin
						base_q <= nref_q + TIME_W'(1) - TIME_W'(tick_q);
					end
				end
				ST_MUL: begin
					if (!have_q || $signed(utime_q) > $signed(newest_q)) begin
						newest_q <= utime_q;
					end
					have_q <= 1'b1;
				end
				default: ;
			endcase
		end
	end

	// sequencer control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q  <= '0;
			keep_q <= '0;
			cnt_q  <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (in_fire) begin
						idx_q  <= IDX_W'(SPF - 1);
						keep_q <= in_keep;
					end
				end
				ST_SEL: begin
					if (!keep_q[idx_q] && idx_q != '0) begin
						idx_q <= idx_q - IDX_W'(1);
					end
				end
				ST_MUL: cnt_q <= CNT_W'(DVD_W - 1);
				ST_DIV: cnt_q <= cnt_q - CNT_W'(1);
				ST_OUT: begin
					if (out_ready && idx_q != '0) begin
						idx_q <= idx_q - IDX_W'(1);
					end
				end
				default: ;
			endcase
		end
	end

	// datapath payload registers
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (in_fire) begin
					flo_q <= frame_low;
					fhi_q <= frame_high;
				end
			end
			ST_SEL: begin
				tick_q  <= tick_cur;
				utime_q <= TIME_W'(tick_cur) + base_q;
				nref_q  <= have_q ? newest_q : '0;
			end
			ST_DIFF: diff_q <= utime_q - nref_q;
			ST_UNW1: begin
				if (in_win) begin
					utime_q <= utime_q - WRAP;
				end
			end
			ST_UNW2: begin
				if (in_win) begin
					utime_q <= utime_q + WRAP;
				end else begin
					utime_q <= nref_q + TIME_W'(1);
				end
			end
			ST_MUL: begin
				dvd_q <= {prod, 8'b0};
				rem_q <= '0;
				den_q <= den_full[SB-1:0];
				sat_q <= den_full[SB-1:0] == '0;
			end
			ST_DIV: begin
				dvd_q <= {dvd_q[DVD_W-2:0], ge};
				rem_q <= ge ? rem_sub[SB-1:0] : rem_sh[SB-1:0];
			end
			default: ;
		endcase
	end

	// last word when no later sample of the frame is kept
	logic [SPF-1:0] lower_mask;
	always_comb begin
		for (int i = 0; i < SPF; i++) begin
			lower_mask[i] = IDX_W'(i) < idx_q;
		end
	end

	logic [QW-1:0] quo_ext;
	assign quo_ext = QW'(dvd_q);

	assign raw_tick      = tick_q;
	assign sample_time   = $signed(utime_q);
	assign adc_value     = $signed(samp);
	assign saturated     = sat_q;
	assign resistance_q8 = (sat_q || quo_ext > QW'(RES_MAX)) ? RES_MAX : quo_ext[RES_W-1:0];
	assign last_of_frame = ~|(keep_q & lower_mask);

	// checks
	a_ready_excl: assert property (@(posedge clk) disable iff (!arst_n)
		!(in_ready && out_valid))
		else $error("input and output sides active together");

	a_out_kept: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> keep_q[idx_q])
		else $error("result word for a skipped sample");

	a_sat_max: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && saturated) |-> resistance_q8 == RES_MAX)
		else $error("saturated word without full-scale resistance");

	a_pause: assert property (@(posedge clk) disable iff (!arst_n)
		(in_fire && cmd == CMD_PAUSE) |=> (paused_q && base_q == BASE_AFTER_CLEAR))
		else $error("pause did not take effect");

	a_div_count: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DIV && cnt_q != '0) |=>
			(state_q == ST_DIV && cnt_q == $past(cnt_q) - CNT_W'(1)))
		else $error("divider left early");

endmodule

`default_nettype wire

// ===== tb/sv/telemetry_frame_unwrap_resistance_unit_tb.sv =====
`timescale 1ns / 1ps

module telemetry_frame_unwrap_resistance_unit_tb;
	import tfu_pkg::*;

	// cycles with no word moving on either channel before the run is called hung
	localparam int unsigned WATCHDOG_LIMIT = 5000;
	// settle wait, long enough to cover a frame still in flight
	localparam int unsigned SETTLE_CYCLES  = 300;
	// long output hold-off used to back the block up into its input
	localparam int unsigned HOLD_CYCLES    = 600;
	localparam logic [63:0] ADC_HALF       = 64'h20_0000;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;
	logic in_valid;
	logic in_ready;
	logic [CMD_W-1:0] cmd;
	logic [FRAME_LO_W-1:0] frame_low;
	logic [FRAME_HI_W-1:0] frame_high;
	logic out_valid;
	logic out_ready;
	logic [9:0] raw_tick;
	logic signed [TIME_W-1:0] sample_time;
	logic signed [21:0] adc_value;
	logic [RES_W-1:0] resistance_q8;
	logic saturated;
	logic last_of_frame;

	telemetry_frame_unwrap_resistance_unit u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.cmd          (cmd),
		.frame_low    (frame_low),
		.frame_high   (frame_high),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.raw_tick     (raw_tick),
		.sample_time  (sample_time),
		.adc_value    (adc_value),
		.resistance_q8(resistance_q8),
		.saturated    (saturated),
		.last_of_frame(last_of_frame)
	);

	// one converted sample as the block should report it
	typedef struct packed {
		logic [9:0]  tick;
		logic [31:0] stamp;
		logic [21:0] adc;
		logic [46:0] ohms_q8;
		logic        sat;
		logic        last;
	} reading_t;

	reading_t expected_readings[$];

	// shadow registers
	logic [WIN_W-1:0] model_window;
	logic [LIM_W-1:0] model_limit;
	logic [OHM_W-1:0] model_ohms;

	// shadow unwrap state
	logic [31:0] model_base;
	logic [31:0] model_newest;
	bit model_have;
	bit model_paused;

	// idling knobs, percent of cycles
	int unsigned send_idle_pct;
	int unsigned recv_idle_pct;

	bit hold_request;
	int unsigned hold_left;
	int unsigned stall_cycles;

	int unsigned error_count;
	int unsigned words_sent;
	int unsigned readings_checked;
	int unsigned settings_used;

	// clock: 10 ns period
	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// absolute distance of two 32-bit times, wrapping
	function automatic logic [31:0] time_gap(logic [31:0] a, logic [31:0] b);
		logic [31:0] d;
		d = a - b;
		if (d[31])
			d = -d;
		return d;
	endfunction

	// advance the shadow state by one input word and queue the readings it yields
	function automatic void predict_readings(logic [1:0] c, logic [63:0] lo, logic [55:0] hi);
		logic [119:0] bits;
		logic [9:0] start;
		logic [9:0] tick;
		logic [31:0] nearest;
		logic [31:0] stamp;
		logic [21:0] raw;
		logic [21:0] vmag;
		logic [63:0] num;
		logic [63:0] den;
		logic [63:0] quo;
		reading_t r;
		reading_t held;
		bit have_held;
		have_held = 0;
		held = '0;
		case (c)
			CMD_CLEAR: begin
				model_have = 0;
				model_newest = '0;
				model_base = BASE_AFTER_CLEAR;
			end
			CMD_PAUSE: begin
				model_paused = 1;
				model_base = BASE_AFTER_CLEAR;
			end
			CMD_RESUME: begin
				model_paused = 0;
			end
			default: begin
				if (!model_paused) begin
					bits = {hi, lo};
					start = bits[9:0];
					// oldest sample first: sample i belongs to tick start - i
					for (int i = 4; i >= 0; i--) begin
						tick = start - 10'(i);
						if ({1'b0, tick} >= model_limit)
							continue;
						nearest = model_have ? model_newest : 32'd0;
						stamp = {22'd0, tick} + model_base;
						if (time_gap(stamp, nearest) > {23'd0, model_window}) begin
							if (time_gap(stamp - 32'd1024, nearest) <= {23'd0, model_window})
								model_base = model_base - 32'd1024;
							else if (time_gap(stamp + 32'd1024, nearest) <= {23'd0, model_window})
								model_base = model_base + 32'd1024;
							else
								model_base = nearest + 32'd1 - {22'd0, tick};
							stamp = {22'd0, tick} + model_base;
						end
						if (!model_have || $signed(stamp) > $signed(model_newest))
							model_newest = stamp;
						model_have = 1;

						// divider ratio on the sign-extended sample
						raw = bits[10 + 22 * i +: 22];
						vmag = raw[21] ? -raw : raw;
						if (raw[21]) begin
							num = ADC_HALF + {42'd0, vmag};
							den = ADC_HALF - {42'd0, vmag};
						end else begin
							num = ADC_HALF - {42'd0, vmag};
							den = ADC_HALF + {42'd0, vmag};
						end
						r.tick = tick;
						r.stamp = stamp;
						r.adc = raw;
						r.last = 0;
						if (den == 0) begin
							r.ohms_q8 = RES_MAX;
							r.sat = 1;
						end else begin
							quo = ({48'd0, model_ohms} * num * 64'd256) / den;
							r.ohms_q8 = (quo > {17'd0, RES_MAX}) ? RES_MAX : quo[46:0];
							r.sat = 0;
						end
						// hold one back so the final one can carry the frame marker
						if (have_held)
							expected_readings.push_back(held);
						held = r;
						have_held = 1;
					end
					if (have_held) begin
						held.last = 1;
						expected_readings.push_back(held);
					end
				end
			end
		endcase
	endfunction

	// offer one word, idling first at random, and hold it until taken
	task automatic send_word(logic [1:0] c, logic [63:0] lo, logic [55:0] hi);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		cmd <= c;
		frame_low <= lo;
		frame_high <= hi;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		predict_readings(c, lo, hi);
		words_sent++;
	endtask

	task automatic send_frame(logic [119:0] f);
		send_word(CMD_FRAME, f[63:0], f[119:64]);
	endtask

	// sample i sits at bit 10 + 22*i
	function automatic logic [119:0] pack_frame(logic [9:0] tick, logic [21:0] s0,
			logic [21:0] s1, logic [21:0] s2, logic [21:0] s3, logic [21:0] s4);
		return {s4, s3, s2, s1, s0, tick};
	endfunction

	// drop valid, drain every expected reading, then let a silent frame finish
	task automatic settle_block();
		in_valid <= 1'b0;
		@(posedge clk);
		while (expected_readings.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// write all three registers back to back while the block is idle
	task automatic set_config(logic [WIN_W-1:0] w, logic [LIM_W-1:0] l, logic [OHM_W-1:0] o);
		settle_block();
		cfg_we <= 1'b1;
		cfg_index <= REG_MATCH_WINDOW;
		cfg_data <= CFG_DATA_W'(w);
		@(posedge clk);
		cfg_index <= REG_TICK_LIMIT;
		cfg_data <= CFG_DATA_W'(l);
		@(posedge clk);
		cfg_index <= REG_REF_OHMS;
		cfg_data <= o;
		@(posedge clk);
		cfg_we <= 1'b0;
		model_window = w;
		model_limit = l;
		model_ohms = o;
		settings_used++;
	endtask

	// commands alone, including a frame that lands while paused
	task automatic test_commands();
		send_word(CMD_RESUME, '0, '0);
		send_word(CMD_PAUSE, '0, '0);
		send_frame(pack_frame(10'd20, 22'h1, 22'h2, 22'h3, 22'h4, 22'h5));
		send_word(CMD_RESUME, '0, '0);
		send_word(CMD_CLEAR, '0, '0);
	endtask

	// sample corners: zero, largest, most negative (zero divisor), minus one
	task automatic test_sample_extremes();
		send_frame(pack_frame(10'd10, 22'h000000, 22'h1FFFFF, 22'h200000, 22'h3FFFFF,
			22'h000001));
		send_frame(pack_frame(10'd15, 22'h155555, 22'h2AAAAA, 22'h0FFFFF, 22'h300000,
			22'h100000));
		// tick 1023: every tick of the frame is past the limit
		send_word(CMD_FRAME, {64{1'b1}}, {56{1'b1}});
		send_word(CMD_FRAME, {64{1'b1}}, '0);
		send_word(CMD_FRAME, '0, {56{1'b1}});
		send_word(CMD_FRAME, '0, '0);
	endtask

	// unwrap paths: backward wrap, forward wrap, rebase, partial skips
	task automatic test_unwrap_cases();
		send_frame(pack_frame(10'd1002, 22'h012345, 22'h23456, 22'h3ABCDE, 22'h0, 22'h1F0000));
		send_frame(pack_frame(10'd3, 22'h054321, 22'h3FFFFE, 22'h200001, 22'h7, 22'h100));
		send_frame(pack_frame(10'd400, 22'h0ABCDE, 22'h1, 22'h2, 22'h3, 22'h4));
		send_frame(pack_frame(10'd0, 22'h111111, 22'h222222, 22'h333333, 22'h3, 22'h0));
	endtask

	// register corners
	task automatic test_register_extremes();
		// exact match only, nothing skipped, largest reference
		set_config(9'd0, 11'd1024, 16'hFFFF);
		send_frame(pack_frame(10'd1023, 22'h0, 22'h1FFFFF, 22'h200000, 22'h3FFFFF, 22'h1));
		send_frame(pack_frame(10'd2, 22'h2AAAAA, 22'h155555, 22'h0, 22'h1, 22'h3FFFFF));
		// every tick skipped
		set_config(9'd511, 11'd0, 16'd0);
		send_frame(pack_frame(10'd4, 22'h1, 22'h2, 22'h3, 22'h4, 22'h200000));
		// only tick 0 kept, zero reference with a zero divisor
		set_config(9'd300, 11'd1, 16'd0);
		send_frame(pack_frame(10'd4, 22'h1, 22'h2, 22'h3, 22'h4, 22'h200000));
	endtask

	// mostly frames with ticks marching forward, commands and jumps mixed in
	task automatic test_random_traffic(int unsigned target, bit with_hold);
		logic [WIN_W-1:0] w;
		logic [LIM_W-1:0] l;
		logic [OHM_W-1:0] o;
		logic [119:0] f;
		logic [1:0] c;
		logic [9:0] cursor;
		logic [21:0] corners [4];
		int unsigned counted;
		int unsigned pick;
		corners = '{22'h000000, 22'h1FFFFF, 22'h200000, 22'h3FFFFF};
		w = ($urandom_range(99) < 20) ? ($urandom_range(1) ? 9'd511 : 9'd0)
			: WIN_W'($urandom_range(200));
		l = ($urandom_range(99) < 30) ? 11'd1024 : LIM_W'($urandom_range(1024, 900));
		o = ($urandom_range(99) < 20) ? 16'hFFFF : OHM_W'($urandom_range(65535));
		set_config(w, l, o);
		// receiver backs off while words keep coming
		if (with_hold)
			hold_request = 1;
		cursor = 10'($urandom_range(1023));
		counted = 0;
		while (counted < target) begin
			pick = $urandom_range(99);
			if (pick < 4)
				c = CMD_CLEAR;
			else if (pick < 8)
				c = CMD_PAUSE;
			else if (pick < 13)
				c = CMD_RESUME;
			else
				c = CMD_FRAME;
			f = 120'({$urandom, $urandom, $urandom, $urandom});
			if ($urandom_range(99) < 80)
				cursor = cursor + 10'($urandom_range(6, 1));
			else
				cursor = 10'($urandom_range(1023));
			f[9:0] = cursor;
			for (int i = 0; i < 5; i++)
				if ($urandom_range(99) < 15)
					f[10 + 22 * i +: 22] = corners[$urandom_range(3)];
			// every word offered counts toward the target
			counted++;
			send_word(c, f[63:0], f[119:64]);
		end
	endtask

	// output side: random back-pressure plus the long hold-off on request
	always @(posedge clk) begin
		if (hold_request) begin
			hold_left = HOLD_CYCLES;
			hold_request = 0;
		end
		if (hold_left > 0) begin
			hold_left--;
			out_ready <= 1'b0;
		end else begin
			out_ready <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	task automatic note_mismatch(string field, logic [63:0] want, logic [63:0] got);
		error_count++;
		if (error_count <= 10)
			$display("mismatch on %s: expected %h got %h", field, want, got);
	endtask

	// each word taken on the output against the oldest expectation
	always @(posedge clk) begin
		reading_t want;
		if (arst_n && out_valid && out_ready) begin
			if (expected_readings.size() == 0) begin
				error_count++;
				if (error_count <= 10)
					$display("unexpected word: tick %h time %h", raw_tick, sample_time);
			end else begin
				want = expected_readings.pop_front();
				readings_checked++;
				if (raw_tick !== want.tick)
					note_mismatch("raw_tick", 64'(want.tick), 64'(raw_tick));
				if ($unsigned(sample_time) !== want.stamp)
					note_mismatch("sample_time", 64'(want.stamp), 64'($unsigned(sample_time)));
				if ($unsigned(adc_value) !== want.adc)
					note_mismatch("adc_value", 64'(want.adc), 64'($unsigned(adc_value)));
				if (resistance_q8 !== want.ohms_q8)
					note_mismatch("resistance_q8", 64'(want.ohms_q8), 64'(resistance_q8));
				if (saturated !== want.sat)
					note_mismatch("saturated", 64'(want.sat), 64'(saturated));
				if (last_of_frame !== want.last)
					note_mismatch("last_of_frame", 64'(want.last), 64'(last_of_frame));
			end
		end
	end

	// hang detector: any word moving on either side resets the count
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready))
			stall_cycles = 0;
		else
			stall_cycles++;
		if (stall_cycles >= WATCHDOG_LIMIT) begin
			$display("timeout: no word moved for %0d cycles", WATCHDOG_LIMIT);
			$display("DONE: errors detected");
			$finish;
		end
	end

	initial begin
		arst_n <= 1'b0;
		in_valid <= 1'b0;
		cmd <= CMD_FRAME;
		frame_low <= '0;
		frame_high <= '0;
		cfg_we <= 1'b0;
		cfg_index <= REG_MATCH_WINDOW;
		cfg_data <= '0;
		out_ready <= 1'b0;
		hold_request = 0;
		hold_left = 0;
		stall_cycles = 0;
		error_count = 0;
		words_sent = 0;
		readings_checked = 0;
		settings_used = 1;
		// register and state values out of reset
		model_window = WIN_RESET;
		model_limit = LIM_RESET;
		model_ohms = OHM_RESET;
		model_base = '0;
		model_newest = '0;
		model_have = 0;
		model_paused = 0;
		// sender mostly busy, receiver mostly stalling
		send_idle_pct = 13;
		recv_idle_pct = 70;

		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_commands();
		test_sample_extremes();
		test_unwrap_cases();
		test_register_extremes();
		test_random_traffic(47, 1);

		// sender mostly idle, receiver mostly ready
		settle_block();
		send_idle_pct = 70;
		recv_idle_pct = 13;
		test_random_traffic(47, 0);

		// back to back, no idling either side
		settle_block();
		send_idle_pct = 0;
		recv_idle_pct = 0;
		test_random_traffic(47, 0);

		settle_block();
		$display("covered %0d input words and %0d result words over %0d register settings",
			words_sent, readings_checked, settings_used);
		$display("three idle mixes plus one %0d-cycle output hold-off", HOLD_CYCLES);
		if (error_count == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule
